/* src/gms_pkg.sv */
// Shared constants and types for the greedy motif search block.
package gms_pkg;

   localparam int MAX_MOTIF   = 16;
   localparam int MAX_SEQS    = 16;
   localparam int MAX_LEN     = 256;
   localparam int STORE_DEPTH = MAX_SEQS * MAX_LEN;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int CNT_DEPTH   = 4 * MAX_MOTIF;
   localparam int CNT_AW      = $clog2(CNT_DEPTH);
   localparam int COL_W       = $clog2(MAX_MOTIF);
   localparam int SEQ_W       = $clog2(MAX_SEQS);
   localparam int POS_W       = $clog2(MAX_LEN);
   localparam int PROD_W      = 64;

   localparam logic [1:0] CSR_MOTIF_LEN = 2'd0;
   localparam logic [1:0] CSR_SEQ_COUNT = 2'd1;
   localparam logic [1:0] CSR_SEQ_LEN   = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_ADD   = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_SCORE = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

endpackage

/* src/gms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* src/greedy_motif_search.sv */
// Greedy motif search top level: base loading, search sequencer, result output.
//
// Usage: write motif_len, seq_count and seq_len through the csr_ channel
// (index, data, valid/ready; ready is always high) while the block is idle.
// Bases go in on req_base, one per cycle, accepted when start is high and
// busy is low; each load writes one entry of the base store. The base that
// completes the clamped seq_count * seq_len bases starts the search and
// raises busy. The search is a sequencer around two memories, the base
// store and the count profile, each read once a cycle with registered data.
// Per first-sequence window it clears the profile, adds that window, scans
// each further sequence for its best profile product and adds the pick,
// then sums the column maxima as the score; this repeats L-k+1 times, for
// window length k and L bases per sequence. Then one result word per sequence goes out
// on consecutive cycles, marked by rsp_valid, rsp_last on the final one,
// and busy falls. The receiver cannot stall. Synchronous reset returns
// the block to idle with load position zero and registers at their
// reset values; the memories are not cleared.
module greedy_motif_search (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_base,
   output logic                      rsp_valid,
   output logic [gms_pkg::SEQ_W-1:0] rsp_seq_index,
   output logic [7:0]                rsp_motif_start,
   output logic [8:0]                rsp_consensus_score,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [8:0]                csr_wdata
);
   import gms_pkg::*;

   state_type state_ff;

   logic [4:0]          motif_len_ff;
   logic [4:0]          seq_count_ff;
   logic [8:0]          seq_len_ff;
   logic [4:0]          k_eff;
   logic [4:0]          n_eff;
   logic [8:0]          len_clip;
   logic [8:0]          len_eff;
   logic [12:0]         total;
   logic [STORE_AW-1:0] load_pos_ff;

   logic [COL_W-1:0]  km1_ff;
   logic [SEQ_W-1:0]  nm1_ff;
   logic [8:0]        len_ff;
   logic [POS_W-1:0]  winm1_ff;
   logic [POS_W-1:0]  i_ff;
   logic [SEQ_W-1:0]  j_ff;
   logic [POS_W-1:0]  w_ff;
   logic [COL_W-1:0]  c_ff;
   logic [2:0]        ph_ff;
   logic [CNT_AW-1:0] clr_ff;
   logic [POS_W-1:0]  add_w_ff;
   logic [POS_W-1:0]  pick_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] bestp_ff;
   logic [1:0]        b_ff;
   logic [4:0]        colmax_ff;
   logic [8:0]        score_ff;
   logic [8:0]        best_score_ff;
   logic              cur_bank_ff;
   logic              best_bank_ff;
   logic [SEQ_W-1:0]  s_ff;
   logic [7:0]        starts_ff [2][MAX_SEQS];

   logic                load_en;
   logic [STORE_AW-1:0] base_raddr;
   logic [POS_W-1:0]    win_sel;
   logic [1:0]          base_rdata;
   logic                cnt_we;
   logic [CNT_AW-1:0]   cnt_waddr;
   logic [4:0]          cnt_wdata;
   logic [CNT_AW-1:0]   cnt_raddr;
   logic [4:0]          cnt_rdata;
   logic [PROD_W-1:0]   prod_in;
   logic [4:0]          colmax_in;
   logic [8:0]          score_in;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign load_en   = start && !busy;

   always_comb begin
      k_eff = (motif_len_ff == 5'd0) ? 5'd1 :
              (motif_len_ff > 5'(MAX_MOTIF)) ? 5'(MAX_MOTIF) : motif_len_ff;
      n_eff = (seq_count_ff == 5'd0) ? 5'd1 :
              (seq_count_ff > 5'(MAX_SEQS)) ? 5'(MAX_SEQS) : seq_count_ff;
      len_clip = (seq_len_ff > 9'(MAX_LEN)) ? 9'(MAX_LEN) : seq_len_ff;
      len_eff  = (len_clip < {4'd0, k_eff}) ? {4'd0, k_eff} : len_clip;
      total    = 13'(n_eff) * 13'(len_eff);
   end

   assign win_sel    = (state_ff == ST_ADD) ? add_w_ff : w_ff;
   assign base_raddr = STORE_AW'(j_ff) * STORE_AW'(len_ff) + STORE_AW'(win_sel)
                       + STORE_AW'(c_ff);

   always_comb begin
      if (state_ff == ST_SCORE) begin
         cnt_raddr = {ph_ff[1:0], c_ff};
      end else begin
         cnt_raddr = {base_rdata, c_ff};
      end
      cnt_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_ADD) && (ph_ff == 3'd2));
      cnt_waddr = (state_ff == ST_CLEAR) ? clr_ff : {b_ff, c_ff};
      cnt_wdata = (state_ff == ST_CLEAR) ? 5'd0 : 5'(cnt_rdata + 5'd1);
      prod_in   = PROD_W'(prod_ff * cnt_rdata);
      colmax_in = (cnt_rdata > colmax_ff) ? cnt_rdata : colmax_ff;
      score_in  = score_ff + 9'(colmax_in);
   end

   gms_ram #(.WIDTH(2), .DEPTH(STORE_DEPTH)) u_base_ram (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_pos_ff),
      .wr_data (req_base),
      .rd_addr (base_raddr),
      .rd_data (base_rdata)
   );

   gms_ram #(.WIDTH(5), .DEPTH(CNT_DEPTH)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         motif_len_ff  <= 5'd8;
         seq_count_ff  <= 5'd16;
         seq_len_ff    <= 9'd256;
         load_pos_ff   <= '0;
         cur_bank_ff   <= 1'b0;
         best_bank_ff  <= 1'b1;
         best_score_ff <= '0;
         ph_ff         <= '0;
         s_ff          <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MOTIF_LEN: motif_len_ff <= csr_wdata[4:0];
               CSR_SEQ_COUNT: seq_count_ff <= csr_wdata[4:0];
               CSR_SEQ_LEN:   seq_len_ff   <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (load_en) begin
                  if (13'(load_pos_ff) + 13'd1 < total) begin
                     load_pos_ff <= load_pos_ff + 1'b1;
                  end else begin
                     load_pos_ff   <= '0;
                     km1_ff        <= COL_W'(k_eff - 5'd1);
                     nm1_ff        <= SEQ_W'(n_eff - 5'd1);
                     len_ff        <= len_eff;
                     winm1_ff      <= POS_W'(len_eff - 9'(k_eff));
                     i_ff          <= '0;
                     clr_ff        <= '0;
                     best_score_ff <= '0;
                     state_ff      <= ST_CLEAR;
                  end
               end
            end
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CNT_AW'(CNT_DEPTH - 1)) begin
                  j_ff     <= '0;
                  add_w_ff <= i_ff;
                  c_ff     <= '0;
                  ph_ff    <= '0;
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               case (ph_ff)
                  3'd0: ph_ff <= 3'd1;
                  3'd1: begin
                     b_ff  <= base_rdata;
                     ph_ff <= 3'd2;
                  end
                  default: begin
                     ph_ff <= 3'd0;
                     if (c_ff == km1_ff) begin
                        c_ff <= '0;
                        starts_ff[cur_bank_ff][j_ff] <= add_w_ff;
                        if (j_ff == nm1_ff) begin
                           score_ff  <= '0;
                           colmax_ff <= '0;
                           state_ff  <= ST_SCORE;
                        end else begin
                           j_ff     <= j_ff + 1'b1;
                           w_ff     <= '0;
                           prod_ff  <= PROD_W'(1);
                           bestp_ff <= '0;
                           pick_ff  <= '0;
                           state_ff <= ST_SCAN;
                        end
                     end else begin
                        c_ff <= c_ff + 1'b1;
                     end
                  end
               endcase
            end
            ST_SCAN: begin
               case (ph_ff)
                  3'd0: ph_ff <= 3'd1;
                  3'd1: ph_ff <= 3'd2;
                  3'd2: begin
                     prod_ff <= prod_in;
                     if (c_ff == km1_ff) begin
                        ph_ff <= 3'd3;
                     end else begin
                        c_ff  <= c_ff + 1'b1;
                        ph_ff <= 3'd0;
                     end
                  end
                  default: begin
                     c_ff    <= '0;
                     ph_ff   <= 3'd0;
                     prod_ff <= PROD_W'(1);
                     if (prod_ff > bestp_ff) begin
                        bestp_ff <= prod_ff;
                        pick_ff  <= w_ff;
                     end
                     if (w_ff == winm1_ff) begin
                        add_w_ff <= (prod_ff > bestp_ff) ? w_ff : pick_ff;
                        state_ff <= ST_ADD;
                     end else begin
                        w_ff <= w_ff + 1'b1;
                     end
                  end
               endcase
            end
            ST_SCORE: begin
               case (ph_ff)
                  3'd0: ph_ff <= 3'd1;
                  3'd1: begin
                     colmax_ff <= cnt_rdata;
                     ph_ff     <= 3'd2;
                  end
                  3'd2, 3'd3: begin
                     colmax_ff <= colmax_in;
                     ph_ff     <= ph_ff + 3'd1;
                  end
                  3'd4: begin
                     score_ff <= score_in;
                     if (c_ff == km1_ff) begin
                        ph_ff <= 3'd5;
                     end else begin
                        c_ff  <= c_ff + 1'b1;
                        ph_ff <= 3'd0;
                     end
                  end
                  default: begin
                     ph_ff <= 3'd0;
                     c_ff  <= '0;
                     if (score_ff > best_score_ff) begin
                        best_score_ff <= score_ff;
                        best_bank_ff  <= cur_bank_ff;
                        cur_bank_ff   <= !cur_bank_ff;
                     end
                     if (i_ff == winm1_ff) begin
                        s_ff     <= '0;
                        state_ff <= ST_EMIT;
                     end else begin
                        i_ff     <= i_ff + 1'b1;
                        clr_ff   <= '0;
                        state_ff <= ST_CLEAR;
                     end
                  end
               endcase
            end
            ST_EMIT: begin
               if (s_ff == nm1_ff) begin
                  s_ff     <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  s_ff <= s_ff + 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = (state_ff == ST_EMIT);
   assign rsp_seq_index       = s_ff;
   assign rsp_motif_start     = starts_ff[best_bank_ff][s_ff];
   assign rsp_consensus_score = best_score_ff;
   assign rsp_last            = (s_ff == nm1_ff);

endmodule
